/* rtl/core/csd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'h48;
  localparam logic [7:0] SYNC_SECOND = 8'h4B;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Header and trailer bytes around the payload.
  localparam logic [15:0] FRAME_OVERHEAD = 16'd10;

  // Version accepted after reset.
  localparam logic [7:0] VERSION_RESET = 8'd1;

  // Byte positions within a frame.
  localparam int POS_VERSION = 2;
  localparam int POS_TYPE    = 3;
  localparam int POS_SEQ_LO  = 4;
  localparam int POS_SEQ_HI  = 5;
  localparam int POS_LEN_LO  = 6;
  localparam int POS_LEN_HI  = 7;
  localparam int POS_PAYLOAD = 8;

  // Payload length as carried internally, and as shown on the result ports.
  localparam int PLEN_W    = 7;
  localparam int OUT_LEN_W = 6;

  // One good frame, as handed from the parser to the emitter.
  typedef struct packed {
    logic [7:0]        msg_type;
    logic [15:0]       seq;
    logic [PLEN_W-1:0] plen;
  } desc_t;

endpackage

`default_nettype wire

/* rtl/core/csd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module csd_front import csd_pkg::*; #(
  parameter int MAX_FRAME_BYTES   = 64,
  parameter int MAX_PAYLOAD_BYTES = 54,
  parameter int IDX_W             = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             q_full,
  output logic                  pl_we,
  output logic [IDX_W-1:0]      pl_waddr,
  output logic [7:0]            pl_wdata,
  output logic                  push,
  output desc_t                 push_desc
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       version;
  logic [7:0]       ver_byte;
  logic [7:0]       type_byte;
  logic [7:0]       seq_lo;
  logic [7:0]       seq_hi;
  logic [7:0]       len_lo;
  logic [7:0]       len_hi;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [7:0]       rx_crc_lo;
  logic             take;
  logic [15:0]      len16;
  logic [15:0]      expected;
  logic [16:0]      crc_limit;
  logic             in_crc;
  logic             is_rx_lo;
  logic             frame_end;
  logic             good;

  // A transfer is taken whenever the frame queue has a free payload bank.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Length field, with the high byte straight from the input when it arrives.
  assign len16     = (count == CNT_W'(POS_LEN_HI)) ? {in_byte, len_lo} : {len_hi, len_lo};
  assign expected  = len16 + FRAME_OVERHEAD;
  assign count_inc = count + CNT_W'(1);
  assign crc_limit = {1'b0, len16} + 17'(POS_PAYLOAD);
  // The header from the version byte on is always covered; the length only bounds the payload part.
  assign in_crc    = (count >= CNT_W'(POS_VERSION)) &&
                     ((count < CNT_W'(POS_PAYLOAD)) || (17'(count) < crc_limit));
  assign is_rx_lo  = (17'(count) == crc_limit);
  assign crc_next  = crc16_byte((count == CNT_W'(POS_VERSION)) ? CRC_INIT : crc, in_byte);

  // Sync hunt and frame length tracking.
  always_comb begin
    count_next = count;
    frame_end  = 1'b0;
    if (count == '0) begin
      count_next = (in_byte == SYNC_FIRST) ? CNT_W'(1) : '0;
    end else if (count == CNT_W'(1)) begin
      if (in_byte == SYNC_SECOND) begin
        count_next = CNT_W'(2);
      end else begin
        count_next = (in_byte == SYNC_FIRST) ? CNT_W'(1) : '0;
      end
    end else if (count_inc < CNT_W'(POS_PAYLOAD)) begin
      count_next = count_inc;
    end else if (expected > 16'(MAX_FRAME_BYTES)) begin
      count_next = '0;
    end else if (16'(count_inc) >= expected) begin
      count_next = '0;
      frame_end  = 1'b1;
    end else begin
      count_next = count_inc;
    end
  end

  // Frame checks on its final byte; the received CRC is little-endian.
  assign good = (expected >= FRAME_OVERHEAD) && (ver_byte == version) &&
                (len16 <= 16'(MAX_PAYLOAD_BYTES)) && ({in_byte, rx_crc_lo} == crc);

  assign push                = take && frame_end && good;
  assign push_desc.msg_type  = type_byte;
  assign push_desc.seq       = {seq_hi, seq_lo};
  assign push_desc.plen      = PLEN_W'(len16);

  // Bytes from the payload onward go to the free bank of the payload buffer.
  assign pl_we    = take && (count >= CNT_W'(POS_PAYLOAD));
  assign pl_waddr = IDX_W'(count - CNT_W'(POS_PAYLOAD));
  assign pl_wdata = in_byte;

  // Control state and the version register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      version <= VERSION_RESET;
    end else begin
      if (cfg_wr_en) begin
        version <= cfg_wr_data;
      end
      if (take) begin
        count <= count_next;
      end
    end
  end

  // Header fields and the running CRC.
  always_ff @(posedge clk) begin
    if (take) begin
      case (count)
        CNT_W'(POS_VERSION): ver_byte  <= in_byte;
        CNT_W'(POS_TYPE):    type_byte <= in_byte;
        CNT_W'(POS_SEQ_LO):  seq_lo    <= in_byte;
        CNT_W'(POS_SEQ_HI):  seq_hi    <= in_byte;
        CNT_W'(POS_LEN_LO):  len_lo    <= in_byte;
        CNT_W'(POS_LEN_HI):  len_hi    <= in_byte;
        default: ;
      endcase
      if (in_crc) begin
        crc <= crc_next;
      end
      if (is_rx_lo) begin
        rx_crc_lo <= in_byte;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/csd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module csd_queue import csd_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pl_we,
  input  wire logic [IDX_W-1:0] pl_waddr,
  input  wire logic [7:0]       pl_wdata,
  input  wire logic             push,
  input  wire desc_t            push_desc,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output desc_t                 head_desc,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic [7:0]            rd_data
);

  // Two frames deep: each entry owns one bank of the payload buffer.
  logic [7:0] buf_mem [2**(IDX_W+1)];
  desc_t      desc_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;

  assign full      = (used == 2'd2);
  assign empty     = (used == 2'd0);
  assign head_desc = desc_q[rd_ptr];

  // Payload buffer: the parser fills the free bank, the emitter reads the head bank.
  always_ff @(posedge clk) begin
    if (pl_we) begin
      buf_mem[{wr_ptr, pl_waddr}] <= pl_wdata;
    end
    if (rd_en) begin
      rd_data <= buf_mem[{rd_ptr, rd_addr}];
    end
  end

  // Frame descriptors.
  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[wr_ptr] <= push_desc;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        used <= used + 2'd1;
      end else if (pop && !push) begin
        used <= used - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/csd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module csd_back import csd_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire desc_t                q_desc,
  output logic                      q_pop,
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  input  wire logic [7:0]           rd_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                msg_type,
  output logic [15:0]               sequence_number,
  output logic [OUT_LEN_W-1:0]      payload_count,
  output logic                      has_payload_byte,
  output logic [OUT_LEN_W-1:0]      payload_index,
  output logic [7:0]                payload_byte,
  output logic                      last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } back_state_t;

  back_state_t       state;
  logic [PLEN_W-1:0] plen;
  logic [PLEN_W-1:0] idx;
  logic [PLEN_W-1:0] idx_inc;

  assign idx_inc = idx + PLEN_W'(1);

  // Buffer reads and the release of a finished frame.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    q_pop   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty && (q_desc.plen != '0)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      ST_SEND: begin
        if (out_ready) begin
          if (last) begin
            q_pop = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Control: pick up a frame, fetch each byte, hold it until transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_desc.plen == '0) begin
              out_valid <= 1'b1;
              state     <= ST_SEND;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          out_valid <= 1'b1;
          state     <= ST_SEND;
        end
        ST_SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= last ? ST_IDLE : ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result fields.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        msg_type         <= q_desc.msg_type;
        sequence_number  <= q_desc.seq;
        payload_count    <= q_desc.plen[OUT_LEN_W-1:0];
        plen             <= q_desc.plen;
        idx              <= '0;
        has_payload_byte <= 1'b0;
        payload_index    <= '0;
        payload_byte     <= 8'd0;
        last             <= 1'b1;
      end
      ST_READ: begin
        has_payload_byte <= 1'b1;
        payload_index    <= idx[OUT_LEN_W-1:0];
        payload_byte     <= rd_data;
        last             <= (idx_inc == plen);
      end
      ST_SEND: begin
        if (out_ready && !last) begin
          idx <= idx_inc;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/crc16_stream_deframer.sv */
// Length-prefixed frame receiver with CRC-16/CCITT-FALSE check.
// Input channel (in_valid/in_ready/in_byte) takes one received byte per
// transfer. The parser hunts for the sync pair, collects the header, checks
// version, length and CRC, and writes the payload into one bank of a two-bank
// buffer. It takes one byte every cycle while a bank is free; with both banks
// holding good frames not yet emitted, in_ready stays low.
// Output channel (out_valid/out_ready and the result fields) gives one transfer
// per payload byte, last marking the final one, or a single transfer with
// has_payload_byte low for an empty frame. Each result takes a buffer read and
// the output register, so results never leave back to back. With the emitter
// idle, a frame's first result passes the queue, the buffer read and the output
// register after its final byte is taken; an empty frame skips the buffer read.
// A stalled receiver holds the current result; the parser keeps taking bytes
// into the free bank meanwhile. Bad frames are dropped with no result.
// cfg_wr_en writes the required version byte at once; it should only change
// while no frame is pending. Reset (rst, synchronous) empties the queue, clears
// the parser and sets the version to 1; the payload buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module crc16_stream_deframer import csd_pkg::*; #(
  parameter int MAX_FRAME_BYTES   = 64,
  parameter int MAX_PAYLOAD_BYTES = 54
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                msg_type,
  output logic [15:0]               sequence_number,
  output logic [OUT_LEN_W-1:0]      payload_count,
  output logic                      has_payload_byte,
  output logic [OUT_LEN_W-1:0]      payload_index,
  output logic [7:0]                payload_byte,
  output logic                      last
);

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             pl_we;
  logic [IDX_W-1:0] pl_waddr;
  logic [7:0]       pl_wdata;
  logic             push;
  desc_t            push_desc;
  desc_t            head_desc;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  // Parser.
  csd_front #(
    .MAX_FRAME_BYTES   (MAX_FRAME_BYTES),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .IDX_W             (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .q_full      (q_full),
    .pl_we       (pl_we),
    .pl_waddr    (pl_waddr),
    .pl_wdata    (pl_wdata),
    .push        (push),
    .push_desc   (push_desc)
  );

  // Frame queue and payload buffer.
  csd_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .pl_we     (pl_we),
    .pl_waddr  (pl_waddr),
    .pl_wdata  (pl_wdata),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_desc (head_desc),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Result emitter.
  csd_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_desc           (head_desc),
    .q_pop            (q_pop),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .msg_type         (msg_type),
    .sequence_number  (sequence_number),
    .payload_count    (payload_count),
    .has_payload_byte (has_payload_byte),
    .payload_index    (payload_index),
    .payload_byte     (payload_byte),
    .last             (last)
  );

endmodule

`default_nettype wire
